// ===== hw/rtl/ckwtb_pkg.sv =====
// Shared types and constants of the color-keyed wrapping tile blit core.
`default_nettype none

package ckwtb_pkg;

  localparam int MaxDimDefault = 1024;

  localparam logic [7:0] TRANSPARENT_INDEX = 8'hFF;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  localparam logic [2:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH   = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_COPY_WIDTH  = 3'd4;
  localparam logic [2:0] REG_COPY_HEIGHT = 3'd5;

  typedef struct packed {
    logic               func;
    logic [9:0]         src_x_start;
    logic [9:0]         src_y_start;
    logic signed [11:0] dst_x_start;
    logic signed [11:0] dst_y_start;
    logic [7:0]         pixel;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [19:0] dst_offset;
    logic [7:0]  write_data;
    logic [19:0] next_src_offset;
    logic        done_res;
    logic        ignored;
  } out_t;

  typedef struct packed {
    logic [10:0] src_width;
    logic [10:0] src_height;
    logic [10:0] dst_width;
    logic [10:0] dst_height;
    logic [10:0] copy_width;
    logic [10:0] copy_height;
  } cfg_t;

  typedef struct packed {
    logic        ignored;
    logic        done;
    logic        write_enable;
    logic [7:0]  write_data;
    logic        dst_hit;
    logic [10:0] dst_col;
    logic [10:0] dst_row;
    logic [10:0] dst_stride;
    logic        src_want;
    logic [10:0] src_col;
    logic [10:0] src_row;
    logic [10:0] src_stride;
  } step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ckwtb_offset.sv =====
// Column-major byte offset unit: column times stride plus row, or zero when disabled.
`default_nettype none

module ckwtb_offset (
  input  wire logic        en_i,
  input  wire logic [10:0] col_i,
  input  wire logic [10:0] stride_i,
  input  wire logic [10:0] row_i,
  output logic [19:0]      offset_o
);

  logic [21:0] prod;
  logic [22:0] sum;

  assign prod = col_i * stride_i;
  assign sum = {1'b0, prod} + {12'd0, row_i};
  assign offset_o = en_i ? sum[19:0] : 20'd0;

endmodule

`default_nettype wire

// ===== hw/rtl/ckwtb_ctrl.sv =====
// Traversal state of the blit and the per-transfer step decode.
`default_nettype none

module ckwtb_ctrl #(
  parameter int MAX_DIM = ckwtb_pkg::MaxDimDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire ckwtb_pkg::in_t   in_i,
  input  wire ckwtb_pkg::cfg_t  cfg_i,
  output ckwtb_pkg::step_t      step_o,
  output logic                  active_o
);

  localparam int CW = (MAX_DIM >= 2048) ? 11 : $clog2(MAX_DIM);

  function automatic logic [10:0] eff(input logic [10:0] v);
    eff = (32'(v) > MAX_DIM) ? 11'(MAX_DIM) : v;
  endfunction

  logic               active_q, active_d;
  logic [10:0]        col_q, col_d;
  logic [10:0]        row_q, row_d;
  logic [CW-1:0]      scol_q, scol_d;
  logic [CW-1:0]      srow_q, srow_d;
  logic [CW-1:0]      srow_start_q, srow_start_d;
  logic signed [11:0] dcs_q, dcs_d;
  logic signed [11:0] drs_q, drs_d;

  logic [10:0] ew, eh, dw, dh;
  logic [10:0] sx_sel, sy_sel;
  logic [12:0] x2, y2;
  logic        hit;
  logic [11:0] row_inc, col_inc, srow_inc, scol_inc;
  logic        row_end, col_end;
  logic [10:0] srow_a, scol_a, srow_b, scol_n;
  logic [10:0] scol_ext, srow_ext, srow_start_ext;

  assign ew = eff(cfg_i.src_width);
  assign eh = eff(cfg_i.src_height);
  assign dw = eff(cfg_i.dst_width);
  assign dh = eff(cfg_i.dst_height);

  assign scol_ext = 11'(scol_q);
  assign srow_ext = 11'(srow_q);
  assign srow_start_ext = 11'(srow_start_q);

  assign sx_sel = ({1'b0, in_i.src_x_start} < ew) ? {1'b0, in_i.src_x_start} : 11'd0;
  assign sy_sel = ({1'b0, in_i.src_y_start} < eh) ? {1'b0, in_i.src_y_start} : 11'd0;

  assign x2 = {dcs_q[11], dcs_q} + {2'b00, col_q};
  assign y2 = {drs_q[11], drs_q} + {2'b00, row_q};
  assign hit = !x2[12] && !y2[12] && (x2[11:0] < {1'b0, dw}) && (y2[11:0] < {1'b0, dh});

  assign row_inc = {1'b0, row_q} + 12'd1;
  assign col_inc = {1'b0, col_q} + 12'd1;
  assign srow_inc = {1'b0, srow_ext} + 12'd1;
  assign scol_inc = {1'b0, scol_ext} + 12'd1;
  assign row_end = row_inc >= {1'b0, cfg_i.copy_height};
  assign col_end = col_inc >= {1'b0, cfg_i.copy_width};
  assign srow_a = (srow_inc >= {1'b0, eh}) ? 11'd0 : srow_inc[10:0];
  assign scol_a = (scol_inc >= {1'b0, ew}) ? 11'd0 : scol_inc[10:0];

  always_comb begin
    active_d = active_q;
    col_d = col_q;
    row_d = row_q;
    scol_d = scol_q;
    srow_d = srow_q;
    srow_start_d = srow_start_q;
    dcs_d = dcs_q;
    drs_d = drs_q;
    srow_b = srow_ext;
    scol_n = scol_ext;
    step_o = '0;
    step_o.dst_col = x2[10:0];
    step_o.dst_row = y2[10:0];
    step_o.dst_stride = dh;
    step_o.src_stride = eh;
    if (in_i.func == ckwtb_pkg::FUNC_START) begin
      scol_d = sx_sel[CW-1:0];
      srow_start_d = sy_sel[CW-1:0];
      srow_d = sy_sel[CW-1:0];
      dcs_d = in_i.dst_x_start;
      drs_d = in_i.dst_y_start;
      col_d = '0;
      row_d = '0;
      if (cfg_i.copy_width == 11'd0 || cfg_i.copy_height == 11'd0) begin
        active_d = 1'b0;
        step_o.done = 1'b1;
      end else begin
        active_d = 1'b1;
        step_o.src_want = 1'b1;
        step_o.src_col = sx_sel;
        step_o.src_row = sy_sel;
      end
    end else if (!active_q) begin
      step_o.ignored = 1'b1;
    end else begin
      step_o.write_data = in_i.pixel;
      step_o.dst_hit = hit;
      step_o.write_enable = hit && (in_i.pixel != ckwtb_pkg::TRANSPARENT_INDEX);
      if (row_end) begin
        row_d = '0;
        srow_b = srow_start_ext;
        scol_n = scol_a;
        if (col_end) begin
          active_d = 1'b0;
          col_d = '0;
          step_o.done = 1'b1;
        end else begin
          col_d = col_inc[10:0];
        end
      end else begin
        row_d = row_inc[10:0];
        srow_b = srow_a;
      end
      scol_d = scol_n[CW-1:0];
      srow_d = (srow_b >= eh) ? '0 : srow_b[CW-1:0];
      step_o.src_want = active_d;
      step_o.src_col = scol_n;
      step_o.src_row = srow_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      col_q <= '0;
      row_q <= '0;
      scol_q <= '0;
      srow_q <= '0;
      srow_start_q <= '0;
      dcs_q <= '0;
      drs_q <= '0;
    end else if (fire_i) begin
      active_q <= active_d;
      col_q <= col_d;
      row_q <= row_d;
      scol_q <= scol_d;
      srow_q <= srow_d;
      srow_start_q <= srow_start_d;
      dcs_q <= dcs_d;
      drs_q <= drs_d;
    end
  end

  assign active_o = active_q;

endmodule

`default_nettype wire

// ===== hw/rtl/color_keyed_wrapping_tile_blit_core.sv =====
// Top level of the color-keyed wrapping tile blit core.
//
// Usage: program the six geometry registers through the write port while the core is
// idle, then send a start transfer (func 0) with the source and destination start
// coordinates. Its result carries next_src_offset, the first source byte to fetch.
// Each following pixel transfer (func 1) carries that byte and returns one destination
// write (write_enable, dst_offset, write_data) plus the next source offset; done_res
// marks the last pixel of the job, or a start whose copy is empty.
// Both channels use valid/ready. An accepted transfer passes through a decode stage
// that advances the traversal state at the accepting edge, then two 11x11 offset
// multipliers feeding the output register.
// The core sustains one transfer per cycle unless the receiver stalls; a new transfer is
// accepted while earlier results are still in flight or waiting in the output register.
// When the receiver stalls, the output register holds its result, the decode stage
// fills, and only then is ready dropped; nothing is lost or repeated.
// Reset clears the job state and both pipeline stages, and sets the geometry
// registers to width and height 1 with an empty copy size.
`default_nettype none

module color_keyed_wrapping_tile_blit_core #(
  parameter int MAX_DIM = ckwtb_pkg::MaxDimDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire ckwtb_pkg::in_t   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ckwtb_pkg::out_t       out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [10:0]      cfg_wdata_i
);

  ckwtb_pkg::cfg_t  cfg_q;
  ckwtb_pkg::step_t step_d, step_q;
  ckwtb_pkg::out_t  out_d, out_q;
  logic             a_valid_q, out_valid_q;
  logic             a_adv, in_fire;
  logic             active;
  logic [19:0]      dst_off, src_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width <= 11'd1;
      cfg_q.src_height <= 11'd1;
      cfg_q.dst_width <= 11'd1;
      cfg_q.dst_height <= 11'd1;
      cfg_q.copy_width <= 11'd0;
      cfg_q.copy_height <= 11'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ckwtb_pkg::REG_SRC_WIDTH:   cfg_q.src_width <= cfg_wdata_i;
        ckwtb_pkg::REG_SRC_HEIGHT:  cfg_q.src_height <= cfg_wdata_i;
        ckwtb_pkg::REG_DST_WIDTH:   cfg_q.dst_width <= cfg_wdata_i;
        ckwtb_pkg::REG_DST_HEIGHT:  cfg_q.dst_height <= cfg_wdata_i;
        ckwtb_pkg::REG_COPY_WIDTH:  cfg_q.copy_width <= cfg_wdata_i;
        ckwtb_pkg::REG_COPY_HEIGHT: cfg_q.copy_height <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign a_adv = !out_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || a_adv;
  assign in_fire = in_valid_i && in_ready_o;

  ckwtb_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (in_fire),
    .in_i    (in_data_i),
    .cfg_i   (cfg_q),
    .step_o  (step_d),
    .active_o(active)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      step_q <= step_d;
    end
  end

  ckwtb_offset u_dst_off (
    .en_i    (step_q.dst_hit),
    .col_i   (step_q.dst_col),
    .stride_i(step_q.dst_stride),
    .row_i   (step_q.dst_row),
    .offset_o(dst_off)
  );

  ckwtb_offset u_src_off (
    .en_i    (step_q.src_want),
    .col_i   (step_q.src_col),
    .stride_i(step_q.src_stride),
    .row_i   (step_q.src_row),
    .offset_o(src_off)
  );

  always_comb begin
    out_d.write_enable = step_q.write_enable;
    out_d.dst_offset = dst_off;
    out_d.write_data = step_q.write_data;
    out_d.next_src_offset = src_off;
    out_d.done_res = step_q.done;
    out_d.ignored = step_q.ignored;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_adv) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && a_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !out_valid_q |=> out_valid_q)
    else $error("Decode stage result did not reach the output register.");

  a_ignored_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.ignored |->
      !out_q.write_enable && !out_q.done_res && out_q.dst_offset == 20'd0 &&
      out_q.next_src_offset == 20'd0)
    else $error("Ignored pixel transfer produced a nonzero result.");

  a_key_never_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.write_enable |-> out_q.write_data != ckwtb_pkg::TRANSPARENT_INDEX)
    else $error("Transparent index was written to the destination.");

  a_idle_pixel_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.func == ckwtb_pkg::FUNC_PIXEL && !active |=> step_q.ignored)
    else $error("Pixel transfer without an active job was not flagged.");

  a_done_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && step_d.done |=> !active)
    else $error("Job still active after its done result.");

endmodule

`default_nettype wire

// ===== tb/tb_color_keyed_wrapping_tile_blit_core.sv =====
// Self-checking testbench for the color-keyed wrapping tile blit core.
`timescale 1ns / 1ps

module tb_color_keyed_wrapping_tile_blit_core;
  import ckwtb_pkg::*;

  localparam int MaxDim = MaxDimDefault;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [10:0] cfg_wdata_i;

  cfg_t geom = cfg_t'{11'd1, 11'd1, 11'd1, 11'd1, 11'd0, 11'd0};
  bit   job_active;
  int   copy_col, copy_row;
  int   src_col_pos, src_row_pos, src_row_base;
  int   dst_col_base, dst_row_base;

  out_t blit_result_q[$];
  out_t want_r;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   error_count;
  int   sent_count;
  int   job_starts;
  int   jobs_done;
  int   enabled_writes;
  int   ignored_pixels;

  color_keyed_wrapping_tile_blit_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int dim_of(logic [10:0] v);
    return (v > MaxDim) ? MaxDim : int'(v);
  endfunction

  function automatic logic [19:0] src_offset_now();
    return 20'(src_col_pos * dim_of(geom.src_height) + src_row_pos);
  endfunction

  function automatic out_t predict_blit(in_t it);
    out_t r;
    int   x2, y2, dw, dh, sw, sh;
    r  = '0;
    sw = dim_of(geom.src_width);
    sh = dim_of(geom.src_height);
    dw = dim_of(geom.dst_width);
    dh = dim_of(geom.dst_height);
    if (it.func == FUNC_START) begin
      src_col_pos  = (int'(it.src_x_start) < sw) ? int'(it.src_x_start) : 0;
      src_row_base = (int'(it.src_y_start) < sh) ? int'(it.src_y_start) : 0;
      src_row_pos  = src_row_base;
      dst_col_base = $signed(it.dst_x_start);
      dst_row_base = $signed(it.dst_y_start);
      copy_col = 0;
      copy_row = 0;
      if (geom.copy_width == 0 || geom.copy_height == 0) begin
        job_active = 1'b0;
        r.done_res = 1'b1;
      end else begin
        job_active = 1'b1;
        r.next_src_offset = src_offset_now();
      end
    end else if (!job_active) begin
      r.ignored = 1'b1;
    end else begin
      x2 = dst_col_base + copy_col;
      y2 = dst_row_base + copy_row;
      r.write_data = it.pixel;
      if (x2 >= 0 && y2 >= 0 && x2 < dw && y2 < dh) begin
        r.dst_offset   = 20'(x2 * dh + y2);
        r.write_enable = (it.pixel != TRANSPARENT_INDEX);
      end
      copy_row++;
      src_row_pos++;
      if (src_row_pos >= sh) src_row_pos = 0;
      if (copy_row >= int'(geom.copy_height)) begin
        copy_row = 0;
        copy_col++;
        src_row_pos = src_row_base;
        src_col_pos++;
        if (src_col_pos >= sw) src_col_pos = 0;
        if (copy_col >= int'(geom.copy_width)) begin
          job_active = 1'b0;
          r.done_res = 1'b1;
          copy_col   = 0;
        end
      end
      if (job_active) r.next_src_offset = src_offset_now();
      if (src_row_pos >= sh) src_row_pos = 0;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      if (error_count < 60) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (blit_result_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing actual %p", $time,
                 out_data_o);
        error_count++;
      end else begin
        want_r = blit_result_q.pop_front();
        check_field("write_enable", 32'(want_r.write_enable),
                    32'(out_data_o.write_enable));
        check_field("dst_offset", 32'(want_r.dst_offset), 32'(out_data_o.dst_offset));
        check_field("write_data", 32'(want_r.write_data), 32'(out_data_o.write_data));
        check_field("next_src_offset", 32'(want_r.next_src_offset),
                    32'(out_data_o.next_src_offset));
        check_field("done_res", 32'(want_r.done_res), 32'(out_data_o.done_res));
        check_field("ignored", 32'(want_r.ignored), 32'(out_data_o.ignored));
        if (want_r.write_enable) enabled_writes++;
        if (want_r.done_res) jobs_done++;
        if (want_r.ignored) ignored_pixels++;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_transfer(in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    blit_result_q.push_back(predict_blit(it));
    sent_count++;
    if (it.func == FUNC_START) job_starts++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (blit_result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [2:0] idx, logic [10:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
  endtask

  task automatic write_geometry(cfg_t c);
    drain_results();
    put_reg(REG_SRC_WIDTH, c.src_width);
    put_reg(REG_SRC_HEIGHT, c.src_height);
    put_reg(REG_DST_WIDTH, c.dst_width);
    put_reg(REG_DST_HEIGHT, c.dst_height);
    put_reg(REG_COPY_WIDTH, c.copy_width);
    put_reg(REG_COPY_HEIGHT, c.copy_height);
    cfg_we_i <= 1'b0;
    geom = c;
  endtask

  function automatic in_t start_item(logic [9:0] sx, logic [9:0] sy,
                                     logic [11:0] dx, logic [11:0] dy);
    in_t it;
    it.func        = FUNC_START;
    it.src_x_start = sx;
    it.src_y_start = sy;
    it.dst_x_start = dx;
    it.dst_y_start = dy;
    it.pixel       = 8'($urandom);
    return it;
  endfunction

  function automatic in_t pixel_item(logic [7:0] p);
    in_t it;
    it.func        = FUNC_PIXEL;
    it.src_x_start = 10'($urandom);
    it.src_y_start = 10'($urandom);
    it.dst_x_start = 12'($urandom);
    it.dst_y_start = 12'($urandom);
    it.pixel       = p;
    return it;
  endfunction

  function automatic logic [7:0] random_pixel();
    return ($urandom_range(5) == 0) ? TRANSPARENT_INDEX : 8'($urandom);
  endfunction

  function automatic logic [10:0] random_dim();
    case ($urandom_range(15))
      0: return 11'd0;
      1: return 11'd1024;
      2: return 11'($urandom_range(1025, 2047));
      3: return 11'd1;
      default: return 11'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [10:0] random_copy_size();
    case ($urandom_range(15))
      0: return 11'd0;
      1: return 11'd2047;
      2: return 11'd1024;
      3: return 11'($urandom_range(13, 40));
      default: return 11'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic cfg_t random_geometry();
    cfg_t c;
    c.src_width   = random_dim();
    c.src_height  = random_dim();
    c.dst_width   = random_dim();
    c.dst_height  = random_dim();
    c.copy_width  = random_copy_size();
    c.copy_height = random_copy_size();
    return c;
  endfunction

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_idle_engine();
    send_transfer(pixel_item(8'h00));
    send_transfer(pixel_item(TRANSPARENT_INDEX));
    send_transfer(start_item(10'd0, 10'd0, 12'd0, 12'd0));
    send_transfer(start_item(10'd1023, 10'd1023, 12'h800, 12'h7FF));
  endtask

  task automatic test_extreme_offsets();
    write_geometry(cfg_t'{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd2, 11'd2});
    send_transfer(start_item(10'd1023, 10'd1023, 12'd1023, 12'd1023));
    send_transfer(pixel_item(8'h55));
    send_transfer(pixel_item(TRANSPARENT_INDEX));
    send_transfer(pixel_item(8'h00));
    send_transfer(pixel_item(8'hFE));
  endtask

  task automatic test_clip_and_restart();
    write_geometry(cfg_t'{11'd4, 11'd3, 11'd5, 11'd4, 11'd2, 11'd2});
    send_transfer(start_item(10'd7, 10'd5, -12'sd1, 12'd3));
    send_transfer(pixel_item(8'h11));
    send_transfer(pixel_item(8'h22));
    send_transfer(start_item(10'd3, 10'd2, 12'd4, -12'sd1));
    repeat (4) send_transfer(pixel_item(random_pixel()));
  endtask

  task automatic test_odd_dimensions();
    write_geometry(cfg_t'{11'd2047, 11'd0, 11'd1500, 11'd0, 11'd2, 11'd2});
    send_transfer(start_item(10'd1023, 10'd5, 12'd0, 12'd0));
    send_transfer(pixel_item(8'h3C));
    send_transfer(pixel_item(8'hC3));
    write_geometry(cfg_t'{11'd0, 11'd2047, 11'd0, 11'd1024, 11'd2047, 11'd2047});
    send_transfer(start_item(10'd9, 10'd1023, 12'd0, 12'd0));
    send_transfer(pixel_item(8'h81));
    send_transfer(pixel_item(8'h7E));
  endtask

  task automatic test_register_change_mid_job();
    write_geometry(cfg_t'{11'd8, 11'd8, 11'd8, 11'd8, 11'd3, 11'd4});
    send_transfer(start_item(10'd6, 10'd6, 12'd1, 12'd1));
    send_transfer(pixel_item(8'hA5));
    send_transfer(pixel_item(8'h5A));
    write_geometry(cfg_t'{11'd8, 11'd8, 11'd8, 11'd8, 11'd3, 11'd1});
    repeat (4) send_transfer(pixel_item(random_pixel()));
  endtask

  task automatic run_random_job();
    int          sw, sh, dw, dh, total, count;
    logic [9:0]  sx, sy;
    logic [11:0] dx, dy;
    sw = dim_of(geom.src_width);
    sh = dim_of(geom.src_height);
    dw = dim_of(geom.dst_width);
    dh = dim_of(geom.dst_height);
    sx = (sw > 0 && $urandom_range(4) != 0) ? 10'($urandom_range(sw - 1)) : 10'($urandom);
    sy = (sh > 0 && $urandom_range(4) != 0) ? 10'($urandom_range(sh - 1)) : 10'($urandom);
    dx = ($urandom_range(9) < 7) ? 12'($urandom_range(dw + 5) - 3) : 12'($urandom);
    dy = ($urandom_range(9) < 7) ? 12'($urandom_range(dh + 5) - 3) : 12'($urandom);
    total = int'(geom.copy_width) * int'(geom.copy_height);
    case ($urandom_range(9))
      0: count = (total > 0) ? $urandom_range(total - 1) : 0;
      1: count = total + $urandom_range(1, 3);
      default: count = total;
    endcase
    if (count > 48) count = $urandom_range(1, 24);
    send_transfer(start_item(sx, sy, dx, dy));
    repeat (count) send_transfer(pixel_item(random_pixel()));
  endtask

  task automatic test_random_jobs();
    int mode;
    int goal;
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: set_idling(0, 0);
        1: set_idling(75, 0);
        2: set_idling(0, 75);
        default: set_idling(31, 31);
      endcase
      goal = sent_count + 275;
      while (sent_count < goal) begin
        write_geometry(random_geometry());
        repeat ($urandom_range(2, 6)) run_random_job();
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_SRC_WIDTH;
    cfg_wdata_i = '0;
    set_idling(0, 0);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_engine();
    test_extreme_offsets();
    test_clip_and_restart();
    test_odd_dimensions();
    test_register_change_mid_job();
    test_random_jobs();
    drain_results();
    $display("Covered %0d transfers with %0d job starts and %0d finished jobs or empty copies,",
             sent_count, job_starts, jobs_done);
    $display("giving %0d enabled writes and %0d ignored pixels.", enabled_writes,
             ignored_pixels);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ckwtb_pkg.sv
hw/rtl/ckwtb_offset.sv
hw/rtl/ckwtb_ctrl.sv
hw/rtl/color_keyed_wrapping_tile_blit_core.sv
tb/tb_color_keyed_wrapping_tile_blit_core.sv
